[rtl/core/cfc_pkg.sv]
// Shared types, constants and the CRC byte-update function for the frame checker.
package cfc_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned CRC_W  = 16;

   localparam logic [CRC_W-1:0] CRC_INIT      = 16'hFFFF;
   localparam logic [CRC_W-1:0] CRC_POLY_RST  = 16'h8408;

   // Frame byte count, saturating at two
   typedef enum logic [1:0] {
      SEEN_NONE = 2'd0,
      SEEN_ONE  = 2'd1,
      SEEN_TWO  = 2'd2
   } seen_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              frame_end;
   } req_type;

   typedef struct packed {
      logic              frame_ok;
      logic [CRC_W-1:0]  computed_checksum;
      logic [CRC_W-1:0]  received_checksum;
      logic              too_short;
   } rsp_type;

   // Reflected CRC-16, one byte, LSB first
   function automatic logic [CRC_W-1:0] crc_feed_byte(
      input logic [CRC_W-1:0]  crc,
      input logic [BYTE_W-1:0] b,
      input logic [CRC_W-1:0]  poly
   );
      logic [CRC_W-1:0]  c;
      logic [BYTE_W-1:0] d;
      c = crc;
      d = b;
      for (int k = 0; k < BYTE_W; k++) begin
         if (c[0] ^ d[0]) begin
            c = (c >> 1) ^ poly;
         end else begin
            c = c >> 1;
         end
         d = d >> 1;
      end
      return c;
   endfunction

endpackage

[rtl/core/cfc_in_stage.sv]
// Input register stage: captures one frame word per cycle while it is empty or its word is being taken.
module cfc_in_stage (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  cfc_pkg::req_type req_payload,
   output logic            out_valid,
   input  logic            out_ready,
   output cfc_pkg::req_type out_word
);

   logic             valid_ff;
   logic             valid_in;
   cfc_pkg::req_type word_ff;
   cfc_pkg::req_type word_in;

   assign req_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      word_in  = word_ff;
      if (req_ready) begin
         valid_in = req_valid;
         word_in  = req_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      word_ff <= word_in;
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

[rtl/core/cfc_frame_core.sv]
// Frame state, CRC update and result register.
module cfc_frame_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [cfc_pkg::CRC_W-1:0]  csr_wr_data,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  cfc_pkg::req_type           in_word,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output cfc_pkg::rsp_type           rsp_payload
);

   logic [cfc_pkg::CRC_W-1:0] poly_ff;
   logic [cfc_pkg::CRC_W-1:0] crc_ff;
   logic [cfc_pkg::CRC_W-1:0] crc_in;
   logic [cfc_pkg::CRC_W-1:0] held_ff;
   logic [cfc_pkg::CRC_W-1:0] held_in;
   cfc_pkg::seen_type         seen_ff;
   cfc_pkg::seen_type         seen_in;
   logic                      out_valid_ff;
   logic                      out_valid_in;
   cfc_pkg::rsp_type          out_ff;
   cfc_pkg::rsp_type          out_in;
   logic                      fire;
   logic [cfc_pkg::CRC_W-1:0] crc_next;
   logic [cfc_pkg::CRC_W-1:0] held_next;
   logic [cfc_pkg::CRC_W-1:0] inv;
   cfc_pkg::seen_type         seen_next;

   // Stall only a frame-ending word while the result slot is still full and not being taken
   assign in_ready = !(in_word.frame_end && out_valid_ff && !rsp_ready);
   assign fire     = in_valid && in_ready;

   always_comb begin
      crc_next  = crc_ff;
      seen_next = seen_ff;
      case (seen_ff)
         cfc_pkg::SEEN_NONE: seen_next = cfc_pkg::SEEN_ONE;
         cfc_pkg::SEEN_ONE:  seen_next = cfc_pkg::SEEN_TWO;
         default: begin
            seen_next = cfc_pkg::SEEN_TWO;
            crc_next  = cfc_pkg::crc_feed_byte(crc_ff, held_ff[15:8], poly_ff);
         end
      endcase
      held_next = {held_ff[7:0], in_word.data_byte};
      inv       = ~crc_next;
   end

   always_comb begin
      crc_in       = crc_ff;
      held_in      = held_ff;
      seen_in      = seen_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      if (fire) begin
         if (in_word.frame_end) begin
            // Emit the result and drop back to the start-of-frame state
            crc_in       = cfc_pkg::CRC_INIT;
            held_in      = '0;
            seen_in      = cfc_pkg::SEEN_NONE;
            out_valid_in = 1'b1;
            if (seen_next != cfc_pkg::SEEN_TWO) begin
               out_in.frame_ok          = 1'b0;
               out_in.computed_checksum = '0;
               out_in.received_checksum = '0;
               out_in.too_short         = 1'b1;
            end else begin
               out_in.computed_checksum = {inv[7:0], inv[15:8]};
               out_in.received_checksum = held_next;
               out_in.frame_ok          = ({inv[7:0], inv[15:8]} == held_next);
               out_in.too_short         = 1'b0;
            end
         end else begin
            crc_in  = crc_next;
            held_in = held_next;
            seen_in = seen_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff      <= cfc_pkg::CRC_POLY_RST;
         crc_ff       <= cfc_pkg::CRC_INIT;
         held_ff      <= '0;
         seen_ff      <= cfc_pkg::SEEN_NONE;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            poly_ff <= csr_wr_data;
         end
         crc_ff       <= crc_in;
         held_ff      <= held_in;
         seen_ff      <= seen_in;
         out_valid_ff <= out_valid_in;
      end
      out_ff <= out_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

endmodule

[rtl/core/crc16_response_frame_checker.sv]
// Top level of the CRC-16 response frame checker.
// Takes one frame byte per cycle with a last-of-frame flag and returns one result per frame:
// the inverted, byte-swapped reflected CRC-16 (init 0xFFFF, polynomial from the csr port,
// reset 0x8408) over every byte but the last two, the last two bytes read big-endian, a
// match flag and a too-short flag for one-byte frames. Sustained rate is one byte per
// cycle; a byte passes the input register, then combinational CRC logic (eight unrolled bit
// steps), and the final byte of a frame loads the result register. Only a frame-ending byte
// waits when the result register is still full and not being taken.
module crc16_response_frame_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [cfc_pkg::CRC_W-1:0] csr_wr_data,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  cfc_pkg::req_type          req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output cfc_pkg::rsp_type          rsp_payload
);

   logic             s1_valid;
   logic             s1_ready;
   cfc_pkg::req_type s1_word;

   cfc_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .out_valid   (s1_valid),
      .out_ready   (s1_ready),
      .out_word    (s1_word)
   );

   cfc_frame_core u_frame_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .in_valid    (s1_valid),
      .in_ready    (s1_ready),
      .in_word     (s1_word),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

[rtl/core/cfc_port_checker.sv]
// Port-level assertions for the frame checker, bound to the top level.
module cfc_port_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input cfc_pkg::rsp_type rsp_payload
);

   // Hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result word changed while stalled");

   a_short_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.too_short |->
         !rsp_payload.frame_ok && rsp_payload.computed_checksum == '0 &&
         rsp_payload.received_checksum == '0)
      else $error("too-short result carries nonzero fields");

   a_ok_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.frame_ok ==
         (!rsp_payload.too_short &&
          rsp_payload.computed_checksum == rsp_payload.received_checksum))
      else $error("frame_ok disagrees with checksums");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind crc16_response_frame_checker cfc_port_checker u_cfc_port_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
